>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SSCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every edge, reset included
`define SSCR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/sscr_pkg.sv
// Shared types and constants for the seven-segment character raster.
// No dependencies.
`default_nettype none

package sscr_pkg;

   typedef logic [1:0] glyph_type;

   localparam glyph_type GLYPH_SPACE = 2'd0;
   localparam glyph_type GLYPH_DASH  = 2'd1;
   localparam glyph_type GLYPH_BAR   = 2'd2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_EMIT   = 1'b1;

   // register index taken from csr_paddr[2]
   localparam logic CSR_SCALE = 1'b0;

   localparam int unsigned SEG_A = 0;
   localparam int unsigned SEG_B = 1;
   localparam int unsigned SEG_C = 2;
   localparam int unsigned SEG_D = 3;
   localparam int unsigned SEG_E = 4;
   localparam int unsigned SEG_F = 5;
   localparam int unsigned SEG_G = 6;

   typedef logic [6:0] segs_type;

   function automatic segs_type seg_of(input logic [3:0] d);
      segs_type s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/scaled_seven_segment_char_raster.sv
// Scaled seven-segment character raster, top level.
// Depends on sscr_pkg and sscr_ram.
//
// Append beats (tuser 0) store one digit. Emit beats (tuser 1) return the next
// raster character: the digit store's registered read is taken in S_READ, and the
// glyph is formed into the output register once the output slot is free.
// An emit with nothing stored, and an append while a raster is under way or the
// store is full, produces no beat. Scale (register 0) is clamped to 1..MAX_SCALE.
`default_nettype none

module scaled_seven_segment_char_raster #(
   parameter int MAX_DIGITS = 8,
   parameter int MAX_SCALE  = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [3:0] digit, [7:4] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // req_tuser: [0] cmd
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: [1:0] glyph, [7:2] zero
   output logic      [7:0]  rsp_tdata,
   // rsp_tuser: [0] row_end
   output logic             rsp_tuser,
   // frame_end
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int DPW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW  = $clog2(MAX_DIGITS + 1);
   localparam int RW  = $clog2(2 * MAX_SCALE + 3);
   localparam int CLW = $clog2(MAX_SCALE + 3);
   localparam int GW  = RW + 1;

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type           state_ff, state_in;
   logic [3:0]          scale_ff, scale_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [DPW-1:0]      dpos_ff, dpos_in;
   logic [CLW-1:0]      col_ff, col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sscr_pkg::glyph_type glyph_ff, glyph_in;
   logic                row_end_ff, row_end_in;
   logic                frame_end_ff, frame_end_in;

   logic                req_fire, slot_free, csr_write, idle_pos;
   logic                wr_en;
   logic [3:0]          rd_digit;
   logic [3:0]          eff_scale;
   logic [GW-1:0]       s_g, s1_g, s2_g, rlast_g, r_g, c_g, last_col_g;
   logic [CW-1:0]       last_digit;
   logic                at_last, rend, fend, hbit;
   sscr_pkg::segs_type  segs;
   sscr_pkg::glyph_type glyph_calc;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign idle_pos   = (row_ff == '0) && (dpos_ff == '0) && (col_ff == '0);
   assign wr_en      = req_fire && (req_tuser == sscr_pkg::CMD_APPEND) && idle_pos &&
                       (count_ff < CW'(MAX_DIGITS));

   // digit store; the read address holds while an emit waits in S_READ
   sscr_ram #(
      .WIDTH (4),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[DPW-1:0]),
      .wr_data (req_tdata[3:0]),
      .rd_addr (dpos_ff),
      .rd_data (rd_digit)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == sscr_pkg::CSR_SCALE) ? {28'd0, scale_ff} : 32'd0;

   // geometry
   always_comb begin
      if (scale_ff == 4'd0) begin
         eff_scale = 4'd1;
      end else if (scale_ff > 4'(MAX_SCALE)) begin
         eff_scale = 4'(MAX_SCALE);
      end else begin
         eff_scale = scale_ff;
      end
      s_g        = GW'(eff_scale);
      s1_g       = s_g + GW'(1);
      s2_g       = s_g + GW'(2);
      rlast_g    = (s_g << 1) + GW'(2);
      r_g        = GW'(row_ff);
      c_g        = GW'(col_ff);
      last_digit = count_ff - CW'(1);
      at_last    = (CW'(dpos_ff) == last_digit);
      last_col_g = at_last ? s1_g : s2_g;
      rend       = at_last && (c_g >= last_col_g);
      fend       = rend && (r_g >= rlast_g);
   end

   always_comb begin
      segs       = sscr_pkg::seg_of(rd_digit);
      glyph_calc = sscr_pkg::GLYPH_SPACE;
      hbit       = 1'b0;
      if (c_g > s1_g || r_g > rlast_g) begin
         glyph_calc = sscr_pkg::GLYPH_SPACE;
      end else if (r_g == '0 || r_g == s1_g || r_g == rlast_g) begin
         if (r_g == '0) begin
            hbit = segs[sscr_pkg::SEG_A];
         end else if (r_g == s1_g) begin
            hbit = segs[sscr_pkg::SEG_G];
         end else begin
            hbit = segs[sscr_pkg::SEG_D];
         end
         if (c_g >= GW'(1) && c_g <= s_g && hbit) begin
            glyph_calc = sscr_pkg::GLYPH_DASH;
         end
      end else if (r_g <= s_g) begin
         if ((c_g == '0 && segs[sscr_pkg::SEG_F]) || (c_g == s1_g && segs[sscr_pkg::SEG_B])) begin
            glyph_calc = sscr_pkg::GLYPH_BAR;
         end
      end else begin
         if ((c_g == '0 && segs[sscr_pkg::SEG_E]) || (c_g == s1_g && segs[sscr_pkg::SEG_C])) begin
            glyph_calc = sscr_pkg::GLYPH_BAR;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      scale_in     = scale_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      dpos_in      = dpos_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      glyph_in     = glyph_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;

      if (csr_write && csr_paddr[2] == sscr_pkg::CSR_SCALE) begin
         scale_in = csr_pwdata[3:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + CW'(1);
            end
            if (req_fire && req_tuser == sscr_pkg::CMD_EMIT && count_ff != '0) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               glyph_in     = glyph_calc;
               row_end_in   = rend;
               frame_end_in = fend;
               state_in     = S_IDLE;
               if (fend) begin
                  count_in = '0;
                  row_in   = '0;
                  dpos_in  = '0;
                  col_in   = '0;
               end else if (rend) begin
                  row_in  = row_ff + RW'(1);
                  dpos_in = '0;
                  col_in  = '0;
               end else if (c_g >= last_col_g) begin
                  dpos_in = dpos_ff + DPW'(1);
                  col_in  = '0;
               end else begin
                  col_in = col_ff + CLW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scale_ff     <= 4'd1;
         count_ff     <= '0;
         row_ff       <= '0;
         dpos_ff      <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         dpos_ff      <= dpos_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      glyph_ff     <= glyph_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, glyph_ff};
   assign rsp_tuser  = row_end_ff;
   assign rsp_tlast  = frame_end_ff;

endmodule

`default_nettype wire

>>> rtl/sscr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module sscr_ram #(
   parameter  int WIDTH = 4,
   parameter  int DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/sscr_check.sv
// Port-level checker for the seven-segment character raster, bound to the top.
// Depends on sscr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sscr_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [2:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   `SSCR_ASSERT(a_glyph_code, rsp_tvalid |-> (rsp_tdata[7:2] == 6'd0) && (rsp_tdata[1:0] == sscr_pkg::GLYPH_SPACE || rsp_tdata[1:0] == sscr_pkg::GLYPH_DASH || rsp_tdata[1:0] == sscr_pkg::GLYPH_BAR), "glyph code out of range")
   `SSCR_ASSERT(a_frame_row, (rsp_tvalid && rsp_tlast) |-> rsp_tuser, "frame end without row end")
   `SSCR_ASSERT(a_beat_source, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser == sscr_pkg::CMD_EMIT, 2), "result beat without an emit")
   `SSCR_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result beat changed")

endmodule

bind scaled_seven_segment_char_raster sscr_check u_sscr_check (.*);

`default_nettype wire

>>> test/sscr_raster_checker.sv
// Scoreboard for the seven-segment character raster: predicts every glyph beat from
// the request and CSR traffic and compares it with the result channel.
// Depends on sscr_pkg.
`timescale 1ns / 1ps

module sscr_raster_checker #(
   parameter int MAX_DIGITS   = 8,
   parameter int MAX_SCALE    = 10,
   parameter int REPORT_LIMIT = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatches,
   output int               pending_chars,
   output int               glyphs_checked
);

   typedef struct packed {
      sscr_pkg::glyph_type glyph;
      logic                row_end;
      logic                frame_end;
   } raster_char_type;

   logic [3:0]      held_digit [0:MAX_DIGITS-1];
   logic [3:0]      held_count;
   logic [4:0]      row_at;
   logic [2:0]      cell_at;
   logic [3:0]      col_at;
   logic [3:0]      scale_reg;
   raster_char_type expected_chars [$];
   int              fail_count;
   int              checked_count;

   function automatic sscr_pkg::segs_type digit_segments(input logic [3:0] d);
      case (d)
         4'd0:    return 7'h3F;
         4'd1:    return 7'h06;
         4'd2:    return 7'h5B;
         4'd3:    return 7'h4F;
         4'd4:    return 7'h66;
         4'd5:    return 7'h6D;
         4'd6:    return 7'h7D;
         4'd7:    return 7'h07;
         4'd8:    return 7'h7F;
         4'd9:    return 7'h6F;
         default: return 7'h00;
      endcase
   endfunction

   function automatic sscr_pkg::glyph_type glyph_for(input sscr_pkg::segs_type segs,
                                                     input int unsigned s,
                                                     input int unsigned r,
                                                     input int unsigned c);
      int unsigned seg_bit;
      if (c > s + 1 || r > 2 * s + 2) return sscr_pkg::GLYPH_SPACE;
      if (r == 0 || r == s + 1 || r == 2 * s + 2) begin
         if (r == 0) seg_bit = sscr_pkg::SEG_A;
         else if (r == s + 1) seg_bit = sscr_pkg::SEG_G;
         else seg_bit = sscr_pkg::SEG_D;
         if (c >= 1 && c <= s && segs[seg_bit]) return sscr_pkg::GLYPH_DASH;
         return sscr_pkg::GLYPH_SPACE;
      end
      if (r <= s) begin
         if (c == 0 && segs[sscr_pkg::SEG_F]) return sscr_pkg::GLYPH_BAR;
         if (c == s + 1 && segs[sscr_pkg::SEG_B]) return sscr_pkg::GLYPH_BAR;
         return sscr_pkg::GLYPH_SPACE;
      end
      if (c == 0 && segs[sscr_pkg::SEG_E]) return sscr_pkg::GLYPH_BAR;
      if (c == s + 1 && segs[sscr_pkg::SEG_C]) return sscr_pkg::GLYPH_BAR;
      return sscr_pkg::GLYPH_SPACE;
   endfunction

   task automatic take_request(input logic cmd, input logic [3:0] dig);
      int unsigned     s;
      int unsigned     last_cell;
      int unsigned     last_col;
      int unsigned     last_row;
      logic            rend;
      logic            fend;
      raster_char_type ch;
      if (cmd == sscr_pkg::CMD_APPEND) begin
         if (row_at == 0 && cell_at == 0 && col_at == 0 && held_count < MAX_DIGITS) begin
            held_digit[held_count[2:0]] = dig;
            held_count = held_count + 1'b1;
         end
      end else if (held_count != 0) begin
         if (scale_reg == 0) s = 1;
         else if (scale_reg > MAX_SCALE) s = MAX_SCALE;
         else s = scale_reg;
         last_cell = held_count - 1;
         if (cell_at > last_cell) cell_at = 3'(last_cell);
         ch.glyph = glyph_for(digit_segments(held_digit[cell_at]), s, row_at, col_at);
         last_col = (cell_at == last_cell) ? s + 1 : s + 2;
         last_row = 2 * s + 2;
         rend = (cell_at == last_cell) && (col_at >= last_col);
         fend = rend && (row_at >= last_row);
         ch.row_end = rend;
         ch.frame_end = fend;
         expected_chars.push_back(ch);
         if (fend) begin
            held_count = '0;
            row_at = '0;
            cell_at = '0;
            col_at = '0;
         end else if (rend) begin
            row_at = row_at + 1'b1;
            cell_at = '0;
            col_at = '0;
         end else if (col_at >= last_col) begin
            cell_at = cell_at + 1'b1;
            col_at = '0;
         end else begin
            col_at = col_at + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      raster_char_type want;
      if (reset) begin
         held_count = '0;
         row_at = '0;
         cell_at = '0;
         col_at = '0;
         scale_reg = 4'd1;
         expected_chars.delete();
         fail_count = 0;
         checked_count = 0;
         mismatches <= 0;
         pending_chars <= 0;
         glyphs_checked <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == sscr_pkg::CSR_SCALE)
            scale_reg = csr_pwdata[3:0];
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: unexpected glyph beat: glyph %0d row_end %b frame_end %b",
                           $time, rsp_tdata[1:0], rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               checked_count++;
               if (rsp_tdata[1:0] !== want.glyph || rsp_tuser !== want.row_end ||
                   rsp_tlast !== want.frame_end) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"%0t: beat %0d: expected glyph %0d row_end %b frame_end %b,",
                               " got glyph %0d row_end %b frame_end %b"},
                              $time, checked_count, want.glyph, want.row_end,
                              want.frame_end, rsp_tdata[1:0], rsp_tuser, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata[3:0]);
         mismatches <= fail_count;
         pending_chars <= expected_chars.size();
         glyphs_checked <= checked_count;
      end
   end

endmodule

>>> test/tb_scaled_seven_segment_char_raster.sv
// Testbench top for the seven-segment character raster: drives digit loads, emit
// beats and scale writes with random gaps and stalls, and reports the verdict.
// Depends on sscr_pkg, scaled_seven_segment_char_raster and sscr_raster_checker.
`timescale 1ns / 1ps

module tb_scaled_seven_segment_char_raster;

   localparam int MAX_DIGITS    = 8;
   localparam int MAX_SCALE     = 10;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [2:0] SCALE_ADDR  = {sscr_pkg::CSR_SCALE, 2'b00};
   localparam logic [2:0] UNUSED_ADDR = {~sscr_pkg::CSR_SCALE, 2'b00};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = sscr_pkg::CMD_APPEND;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          pending_chars;
   int          glyphs_checked;
   int          frames_closed = 0;
   int          cycles = 0;
   logic        calm = 1'b0;
   logic [3:0]  scale_now = 4'd1;

   scaled_seven_segment_char_raster #(
      .MAX_DIGITS(MAX_DIGITS),
      .MAX_SCALE (MAX_SCALE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   sscr_raster_checker #(
      .MAX_DIGITS(MAX_DIGITS),
      .MAX_SCALE (MAX_SCALE)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .mismatches    (mismatches),
      .pending_chars (pending_chars),
      .glyphs_checked(glyphs_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tlast) frames_closed <= frames_closed + 1;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("scaled_seven_segment_char_raster: mismatch");
         $finish;
      end
   end

   function automatic int unsigned drawn_scale(input logic [3:0] v);
      if (v == 0) return 1;
      if (v > MAX_SCALE) return MAX_SCALE;
      return v;
   endfunction

   function automatic int unsigned raster_length(input int unsigned s, input int unsigned n);
      return (2 * s + 3) * (n * (s + 3) - 1);
   endfunction

   task automatic send_beat(input logic cmd, input logic [3:0] dig);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, dig};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits carry junk, only [3:0] is the scale
   task automatic write_scale(input logic [3:0] v);
      write_csr(SCALE_ADDR, ($urandom() & 32'hFFFF_FFF0) | v);
      scale_now = v;
   endtask

   // stray_at: ignored load before that emit; pause_at: drain before that emit
   task automatic emit_run(input int unsigned count, input int unsigned stray_at,
                           input int unsigned pause_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == stray_at) send_beat(sscr_pkg::CMD_APPEND, 4'($urandom_range(15)));
         if (i == pause_at) settle();
         send_beat(sscr_pkg::CMD_EMIT, 4'($urandom_range(15)));
      end
   endtask

   // used after a scale change mid-raster, where the remaining length is not fixed
   task automatic emit_until_close();
      int closed_at_start;
      closed_at_start = frames_closed;
      while (frames_closed == closed_at_start)
         send_beat(sscr_pkg::CMD_EMIT, 4'($urandom_range(15)));
   endtask

   initial begin : stimulus
      int unsigned items_done;
      int unsigned frame_no;
      int unsigned n_digits;
      int unsigned eff;
      int unsigned length;
      int unsigned stray_at;
      int unsigned pause_at;
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(sscr_pkg::CMD_EMIT, 4'd0);
      settle();
      write_csr(UNUSED_ADDR, 32'd3);
      for (int d = 0; d < MAX_DIGITS; d++) send_beat(sscr_pkg::CMD_APPEND, 4'(d));
      send_beat(sscr_pkg::CMD_APPEND, 4'd9);
      emit_run(raster_length(1, MAX_DIGITS), 20, raster_length(1, MAX_DIGITS));
      send_beat(sscr_pkg::CMD_APPEND, 4'd8);
      send_beat(sscr_pkg::CMD_APPEND, 4'd9);
      send_beat(sscr_pkg::CMD_APPEND, 4'd15);
      emit_run(raster_length(1, 3), 7, 30);

      // shrink mid-raster: column past the new glyph width
      settle();
      write_scale(4'd15);
      send_beat(sscr_pkg::CMD_APPEND, 4'd8);
      emit_run(30, 30, 30);
      settle();
      write_scale(4'd0);
      emit_until_close();

      // shrink mid-raster: row past the new glyph height
      settle();
      write_scale(4'd3);
      send_beat(sscr_pkg::CMD_APPEND, 4'd8);
      send_beat(sscr_pkg::CMD_APPEND, 4'd8);
      emit_run(70, 70, 70);
      settle();
      write_scale(4'd1);
      emit_until_close();

      // grow mid-raster
      settle();
      send_beat(sscr_pkg::CMD_APPEND, 4'd2);
      send_beat(sscr_pkg::CMD_APPEND, 4'd5);
      emit_run(10, 10, 10);
      settle();
      write_scale(4'd2);
      emit_until_close();
      settle();

      items_done = 0;
      frame_no = 0;
      while (items_done < RANDOM_ITEMS) begin
         calm <= (frame_no >= 4 && frame_no < 9);
         if ($urandom_range(99) < 35) begin
            settle();
            pick = $urandom_range(99);
            if (pick < 55) write_scale(4'($urandom_range(1, 2)));
            else if (pick < 70) write_scale(4'd3);
            else if (pick < 80) write_scale(4'd0);
            else if (pick < 88) write_scale(4'($urandom_range(4, 9)));
            else if (pick < 95) write_scale(4'($urandom_range(10, 14)));
            else write_scale(4'd15);
         end
         eff = drawn_scale(scale_now);
         if (eff >= 4) n_digits = 1;
         else if (eff == 3) n_digits = $urandom_range(1, 2);
         else if (eff == 1 && $urandom_range(11) == 0) n_digits = MAX_DIGITS;
         else n_digits = $urandom_range(1, 3);
         if ($urandom_range(9) == 0) send_beat(sscr_pkg::CMD_EMIT, 4'($urandom_range(15)));
         for (int unsigned k = 0; k < n_digits; k++)
            send_beat(sscr_pkg::CMD_APPEND,
                      4'(($urandom_range(99) < 85) ? $urandom_range(9)
                                                   : $urandom_range(10, 15)));
         if (n_digits == MAX_DIGITS) begin
            send_beat(sscr_pkg::CMD_APPEND, 4'($urandom_range(15)));
            send_beat(sscr_pkg::CMD_APPEND, 4'($urandom_range(15)));
         end
         length = raster_length(eff, n_digits);
         stray_at = ($urandom_range(99) < 15) ? $urandom_range(1, length - 1) : length;
         pause_at = ($urandom_range(99) < 12) ? $urandom_range(1, length - 1) : length;
         emit_run(length, stray_at, pause_at);
         items_done += n_digits + length;
         frame_no++;
      end

      settle();
      $display("Run covered %0d rasters and %0d checked glyph beats: all digit codes, clamped",
               frames_closed, glyphs_checked);
      $display("and mid-raster scale writes, full-store, stray and empty-store requests.");
      if (mismatches == 0)
         $display("scaled_seven_segment_char_raster: match");
      else
         $display("scaled_seven_segment_char_raster: mismatch");
      $finish;
   end

endmodule
